// File: src/ledbb_pkg.sv
// shared types and constants for the led breathe and blink controller
package ledbb_pkg;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam int COUNT_W = 16;
  localparam int CODE_W  = 3;
  localparam int VALUE_W = 11;
  localparam int PEAK_W  = 10;
  localparam int STEP_W  = 8;
  localparam int SHIFT_W = 4;
  localparam int HALF_W  = 8;
  localparam int DUTY_W  = 15;
  localparam int SQ_W    = 2 * VALUE_W;

  localparam logic [DUTY_W-1:0] DUTY_MAX = {DUTY_W{1'b1}};

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_STEP_SIZE        = 2'd0;
  localparam logic [1:0] REG_PEAK_LEVEL       = 2'd1;
  localparam logic [1:0] REG_EASE_SHIFT       = 2'd2;
  localparam logic [1:0] REG_BLINK_HALF_TICKS = 2'd3;

  localparam logic [STEP_W-1:0]  STEP_SIZE_RESET        = 8'd10;
  localparam logic [PEAK_W-1:0]  PEAK_LEVEL_RESET       = 10'd1000;
  localparam logic [SHIFT_W-1:0] EASE_SHIFT_RESET       = 4'd5;
  localparam logic [HALF_W-1:0]  BLINK_HALF_TICKS_RESET = 8'd25;

  // event codes
  localparam logic [CODE_W-1:0] EVT_OFF     = 3'd0;
  localparam logic [CODE_W-1:0] EVT_ON      = 3'd1;
  localparam logic [CODE_W-1:0] EVT_BREATHE = 3'd2;
  localparam logic [CODE_W-1:0] EVT_BLINK   = 3'd3;

  typedef enum logic [2:0] {
    MODE_OFF     = 3'b001,
    MODE_ON      = 3'b010,
    MODE_BREATHE = 3'b100
  } lasting_mode_t;

endpackage

// File: src/ledbb_if.sv
// item and result channel interfaces of the led breathe and blink controller
interface ledbb_item_if;
  import ledbb_pkg::*;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [CODE_W-1:0]  event_code;
  logic [COUNT_W-1:0] blink_count;

  modport source (output valid, output mode, output event_code, output blink_count,
                  input ready);
  modport sink   (input valid, input mode, input event_code, input blink_count,
                  output ready);
endinterface

interface ledbb_result_if;
  import ledbb_pkg::*;
  logic              valid;
  logic              ready;
  logic              led_level;
  logic              pwm_enable;
  logic [DUTY_W-1:0] pwm_duty;
  logic              blink_active;
  logic              event_ignored;

  modport source (output valid, output led_level, output pwm_enable, output pwm_duty,
                  output blink_active, output event_ignored, input ready);
  modport sink   (input valid, input led_level, input pwm_enable, input pwm_duty,
                  input blink_active, input event_ignored, output ready);
endinterface

// File: src/led_breathe_blink_controller_top.sv
// Status LED controller with off, on and breathing modes and blink sequences.
// Every accepted item yields exactly one result. An item is registered at its
// transfer, evaluated against the mode state by one pass of logic (step, shift,
// one 11 by 11 squarer) and placed in the result register; a new item can be
// taken every cycle, and the input stalls only while the result register holds
// a result that is not taken. Configuration is written through the APB port at
// byte addresses 0, 4, 8, 12 (step_size, peak_level, ease_shift,
// blink_half_ticks) while the block is idle, a rule on the user that the block does not enforce.
module led_breathe_blink_controller_top (
  input  logic                         clk,
  input  logic                         rst,
  ledbb_item_if.sink                   item,
  ledbb_result_if.source               result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ledbb_pkg::ADDR_W-1:0] paddr,
  input  logic [ledbb_pkg::DATA_W-1:0] pwdata,
  output logic [ledbb_pkg::DATA_W-1:0] prdata,
  output logic                         pready
);
  import ledbb_pkg::*;

  // configuration registers
  logic [STEP_W-1:0]  step_size;
  logic [PEAK_W-1:0]  peak_level;
  logic [SHIFT_W-1:0] ease_shift;
  logic [HALF_W-1:0]  blink_half_ticks;

  logic [1:0] reg_index;
  assign reg_index = paddr[3:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size        <= STEP_SIZE_RESET;
      peak_level       <= PEAK_LEVEL_RESET;
      ease_shift       <= EASE_SHIFT_RESET;
      blink_half_ticks <= BLINK_HALF_TICKS_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_index)
        REG_STEP_SIZE:        step_size        <= pwdata[STEP_W-1:0];
        REG_PEAK_LEVEL:       peak_level       <= pwdata[PEAK_W-1:0];
        REG_EASE_SHIFT:       ease_shift       <= pwdata[SHIFT_W-1:0];
        REG_BLINK_HALF_TICKS: blink_half_ticks <= pwdata[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_STEP_SIZE:        prdata = {{(DATA_W-STEP_W){1'b0}}, step_size};
      REG_PEAK_LEVEL:       prdata = {{(DATA_W-PEAK_W){1'b0}}, peak_level};
      REG_EASE_SHIFT:       prdata = {{(DATA_W-SHIFT_W){1'b0}}, ease_shift};
      REG_BLINK_HALF_TICKS: prdata = {{(DATA_W-HALF_W){1'b0}}, blink_half_ticks};
      default:              prdata = '0;
    endcase
  end

  // input register
  logic               in_valid;
  logic               in_mode;
  logic [CODE_W-1:0]  in_code;
  logic [COUNT_W-1:0] in_count;
  logic               advance;

  assign advance    = in_valid && (!result.valid || result.ready);
  assign item.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_mode  <= item.mode;
      in_code  <= item.event_code;
      in_count <= item.blink_count;
    end
  end

  // mode state
  lasting_mode_t      lasting_mode, lasting_mode_next;
  logic [VALUE_W-1:0] breath_value, breath_value_next;
  logic               breath_down, breath_down_next;
  logic [COUNT_W-1:0] blinks_left, blinks_left_next;
  logic [HALF_W-1:0]  phase_ticks, phase_ticks_next;
  logic               blink_on_phase, blink_on_phase_next;
  logic               pin_level, pin_level_next;
  logic [DUTY_W-1:0]  duty_reg, duty_reg_next;
  logic               ignored;

  // breathing step
  logic               turn_down;
  logic [VALUE_W-1:0] step_ext;
  logic [VALUE_W-1:0] value_stepped;
  logic [VALUE_W-1:0] eased;
  logic [SQ_W-1:0]    square;
  logic [DUTY_W-1:0]  duty_sat;
  logic [HALF_W-1:0]  phase_inc;

  always_comb begin
    step_ext = {{(VALUE_W-STEP_W){1'b0}}, step_size};
    if (breath_value >= {{(VALUE_W-PEAK_W){1'b0}}, peak_level}) begin
      turn_down = 1'b1;
    end else if (breath_value == '0) begin
      turn_down = 1'b0;
    end else begin
      turn_down = breath_down;
    end
    if (turn_down) begin
      value_stepped = (breath_value > step_ext) ? breath_value - step_ext : '0;
    end else begin
      value_stepped = breath_value + step_ext;
    end
    eased    = value_stepped >> ease_shift;
    square   = {{(SQ_W-VALUE_W){1'b0}}, eased} * {{(SQ_W-VALUE_W){1'b0}}, eased};
    duty_sat = (square > {{(SQ_W-DUTY_W){1'b0}}, DUTY_MAX}) ? DUTY_MAX : square[DUTY_W-1:0];
    phase_inc = phase_ticks + 1'b1;
  end

  always_comb begin
    lasting_mode_next   = lasting_mode;
    breath_value_next   = breath_value;
    breath_down_next    = breath_down;
    blinks_left_next    = blinks_left;
    phase_ticks_next    = phase_ticks;
    blink_on_phase_next = blink_on_phase;
    pin_level_next      = pin_level;
    duty_reg_next       = duty_reg;
    ignored             = 1'b0;

    if (!in_mode) begin
      if (blinks_left != '0) begin
        if (phase_inc < blink_half_ticks) begin
          phase_ticks_next = phase_inc;
        end else begin
          phase_ticks_next = '0;
          if (blink_on_phase) begin
            blink_on_phase_next = 1'b0;
            pin_level_next      = 1'b0;
          end else begin
            blinks_left_next = blinks_left - 1'b1;
            if (blinks_left != {{(COUNT_W-1){1'b0}}, 1'b1}) begin
              blink_on_phase_next = 1'b1;
              pin_level_next      = 1'b1;
            end else begin
              pin_level_next = (lasting_mode == MODE_ON);
            end
          end
        end
      end else if (lasting_mode == MODE_BREATHE) begin
        breath_down_next  = turn_down;
        breath_value_next = value_stepped;
        duty_reg_next     = duty_sat;
      end
    end else if (blinks_left != '0) begin
      ignored = 1'b1;
    end else begin
      case (in_code)
        EVT_OFF: begin
          lasting_mode_next = MODE_OFF;
          pin_level_next    = 1'b0;
        end
        EVT_ON: begin
          lasting_mode_next = MODE_ON;
          pin_level_next    = 1'b1;
        end
        EVT_BREATHE: begin
          lasting_mode_next = MODE_BREATHE;
        end
        EVT_BLINK: begin
          if (in_count != '0) begin
            blinks_left_next    = in_count;
            phase_ticks_next    = '0;
            blink_on_phase_next = 1'b1;
            pin_level_next      = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lasting_mode   <= MODE_BREATHE;
      breath_value   <= '0;
      breath_down    <= 1'b0;
      blinks_left    <= '0;
      phase_ticks    <= '0;
      blink_on_phase <= 1'b0;
      pin_level      <= 1'b0;
      duty_reg       <= '0;
    end else if (advance) begin
      lasting_mode   <= lasting_mode_next;
      breath_value   <= breath_value_next;
      breath_down    <= breath_down_next;
      blinks_left    <= blinks_left_next;
      phase_ticks    <= phase_ticks_next;
      blink_on_phase <= blink_on_phase_next;
      pin_level      <= pin_level_next;
      duty_reg       <= duty_reg_next;
    end
  end

  // result register
  logic pwm_on;
  assign pwm_on = (lasting_mode_next == MODE_BREATHE) && (blinks_left_next == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.led_level     <= pwm_on ? 1'b0 : pin_level_next;
      result.pwm_enable    <= pwm_on;
      result.pwm_duty      <= duty_reg_next;
      result.blink_active  <= (blinks_left_next != '0);
      result.event_ignored <= ignored;
    end
  end

endmodule

// File: src/ledbb_checker.sv
// port-level assertions for the led breathe and blink controller and their bind
module ledbb_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         led_level,
  input logic                         pwm_enable,
  input logic [ledbb_pkg::DUTY_W-1:0] pwm_duty,
  input logic                         blink_active,
  input logic                         event_ignored
);
  import ledbb_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pwm_duty) && $stable(led_level)
      && $stable(pwm_enable) && $stable(blink_active) && $stable(event_ignored))
    else $error("stalled result changed");

  // the input side stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a waiting result");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("result pending after reset");

  // a dropped event only happens inside a running blink, which disables pwm
  a_ignored_blink: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_ignored |-> blink_active && !pwm_enable)
    else $error("event dropped outside a blink");

  // pwm and the direct pin never drive together
  a_pin_pwm: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && pwm_enable |-> !led_level && !blink_active)
    else $error("pin driven while pwm enabled");

endmodule

bind led_breathe_blink_controller_top ledbb_checker u_ledbb_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (item.ready),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .led_level     (result.led_level),
  .pwm_enable    (result.pwm_enable),
  .pwm_duty      (result.pwm_duty),
  .blink_active  (result.blink_active),
  .event_ignored (result.event_ignored)
);
